[design/single_wire_level_command_transmitter_defines.svh]
// Assertion macros shared by the single-wire level command transmitter RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SINGLE_WIRE_LEVEL_COMMAND_TRANSMITTER_DEFINES_SVH
`define SINGLE_WIRE_LEVEL_COMMAND_TRANSMITTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWLCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swlct: same-cycle property violated");

// Next-cycle implication, checked outside reset.
`define SWLCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swlct: next-cycle property violated");

`endif

[design/swlct_pkg.sv]
// Package for the single-wire level command transmitter: types, codes, helpers.
// Depends on nothing; used by the interfaces, the sequencer and the top level.
package swlct_pkg;

    localparam int COUNT_BITS = 16;

    localparam int KIND_W  = 2;
    localparam int LEVEL_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENABLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_TIME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_DELAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_WINDOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_TIME     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 3'd7;

    localparam logic [4:0] LEVEL_MAX = 5'd31;
    localparam logic [2:0] LAST_BIT  = 3'd7;

    localparam logic [32:0] DUR_CAP = (33'd1 << COUNT_BITS) - 33'd1;

    typedef struct packed {
        logic [7:0]  short_time;
        logic [7:0]  long_time;
        logic [15:0] shutdown_time;
        logic [15:0] detect_delay;
        logic [15:0] detect_window;
        logic [15:0] settle_time;
        logic [15:0] latch_time;
        logic [7:0]  device_address;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        short_time:     8'd5,
        long_time:      8'd15,
        shutdown_time:  16'd5000,
        detect_delay:   16'd100,
        detect_window:  16'd260,
        settle_time:    16'd50,
        latch_time:     16'd30,
        device_address: 8'd114
    };

    typedef struct packed {
        logic line;
        logic busy_res;
        logic rejected;
    } t_result;

    typedef enum logic [13:0] {
        PH_IDLE       = 14'b00000000000001,
        PH_EN_SHUT    = 14'b00000000000010,
        PH_EN_DELAY   = 14'b00000000000100,
        PH_EN_DETECT  = 14'b00000000001000,
        PH_EN_SETTLE  = 14'b00000000010000,
        PH_ADDR_LOW   = 14'b00000000100000,
        PH_ADDR_HIGH  = 14'b00000001000000,
        PH_GAP_HIGH_A = 14'b00000010000000,
        PH_GAP_LOW    = 14'b00000100000000,
        PH_GAP_HIGH_B = 14'b00001000000000,
        PH_DATA_LOW   = 14'b00010000000000,
        PH_DATA_HIGH  = 14'b00100000000000,
        PH_END_LOW    = 14'b01000000000000,
        PH_END_HIGH   = 14'b10000000000000
    } t_phase;

    // Segment duration: a zero setting counts as one microsecond, and a
    // setting beyond the counter saturates at its top value.
    function automatic logic [COUNT_BITS-1:0] dur(input logic [15:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w > DUR_CAP) begin
            w = DUR_CAP;
        end
        if (w == 33'd0) begin
            w = 33'd1;
        end
        return w[COUNT_BITS-1:0];
    endfunction

endpackage

[design/swlct_ifs.sv]
// Valid/ready channel interfaces of the single-wire level command transmitter.
// Depends on swlct_pkg for the payload widths.
interface swlct_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [swlct_pkg::KIND_W-1:0]       kind;
    logic [swlct_pkg::LEVEL_W-1:0]      level;

    modport source (output valid, output kind, output level, input ready);
    modport sink   (input valid, input kind, input level, output ready);
endinterface

interface swlct_res_if;
    logic valid;
    logic ready;
    logic line;
    logic busy_res;
    logic rejected;

    modport source (output valid, output line, output busy_res, output rejected, input ready);
    modport sink   (input valid, input line, input busy_res, input rejected, output ready);
endinterface

interface swlct_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [swlct_pkg::CFG_IDX_W-1:0]     index;
    logic [swlct_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/swlct_seq.sv]
// Segment sequencer: holds the line state and applies one request per step.
// Depends on swlct_pkg for the phase encoding, config struct and result struct.
module swlct_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [swlct_pkg::KIND_W-1:0]      i_kind,
    input  logic [swlct_pkg::LEVEL_W-1:0]     i_level,
    input  swlct_pkg::t_cfg                   i_cfg,
    output swlct_pkg::t_result                o_res
);

    swlct_pkg::t_phase                     r_phase, n_phase, target;
    logic [swlct_pkg::COUNT_BITS-1:0]      r_remaining, n_remaining;
    logic [swlct_pkg::COUNT_BITS-1:0]      cnt_next;
    logic [2:0]                            r_bit_index, n_bit_index;
    logic [7:0]                            r_shift, n_shift;
    logic                                  r_line, n_line;
    logic [4:0]                            r_pending, n_pending;
    logic                                  enter;
    logic                                  rej;
    logic                                  busy;

    assign busy = (r_phase != swlct_pkg::PH_IDLE);

    // Request decode and segment advance.
    always_comb begin
        n_bit_index = r_bit_index;
        n_shift     = r_shift;
        n_pending   = r_pending;
        cnt_next    = r_remaining;
        enter       = 1'b0;
        target      = r_phase;
        rej         = 1'b0;
        case (i_kind)
            swlct_pkg::KIND_TICK: begin
                if (busy) begin
                    if (r_remaining > swlct_pkg::COUNT_BITS'(1)) begin
                        cnt_next = r_remaining - swlct_pkg::COUNT_BITS'(1);
                    end else begin
                        enter = 1'b1;
                        case (r_phase)
                            swlct_pkg::PH_EN_SHUT:    target = swlct_pkg::PH_EN_DELAY;
                            swlct_pkg::PH_EN_DELAY:   target = swlct_pkg::PH_EN_DETECT;
                            swlct_pkg::PH_EN_DETECT:  target = swlct_pkg::PH_EN_SETTLE;
                            swlct_pkg::PH_ADDR_LOW:   target = swlct_pkg::PH_ADDR_HIGH;
                            swlct_pkg::PH_DATA_LOW:   target = swlct_pkg::PH_DATA_HIGH;
                            swlct_pkg::PH_ADDR_HIGH,
                            swlct_pkg::PH_DATA_HIGH: begin
                                if (r_bit_index != swlct_pkg::LAST_BIT) begin
                                    n_bit_index = r_bit_index + 3'd1;
                                    n_shift     = {r_shift[6:0], 1'b0};
                                    target      = (r_phase == swlct_pkg::PH_ADDR_HIGH) ?
                                                  swlct_pkg::PH_ADDR_LOW : swlct_pkg::PH_DATA_LOW;
                                end else begin
                                    target      = (r_phase == swlct_pkg::PH_ADDR_HIGH) ?
                                                  swlct_pkg::PH_GAP_HIGH_A : swlct_pkg::PH_END_LOW;
                                end
                            end
                            swlct_pkg::PH_GAP_HIGH_A: target = swlct_pkg::PH_GAP_LOW;
                            swlct_pkg::PH_GAP_LOW:    target = swlct_pkg::PH_GAP_HIGH_B;
                            swlct_pkg::PH_GAP_HIGH_B: begin
                                n_bit_index = 3'd0;
                                n_shift     = {3'b000, r_pending};
                                target      = swlct_pkg::PH_DATA_LOW;
                            end
                            swlct_pkg::PH_END_LOW:    target = swlct_pkg::PH_END_HIGH;
                            default:                  target = swlct_pkg::PH_IDLE;
                        endcase
                    end
                end
            end
            swlct_pkg::KIND_ENABLE: begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    enter  = 1'b1;
                    target = swlct_pkg::PH_EN_SHUT;
                end
            end
            swlct_pkg::KIND_SET: begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    n_pending   = (i_level > 8'(swlct_pkg::LEVEL_MAX)) ?
                                  swlct_pkg::LEVEL_MAX : i_level[4:0];
                    n_shift     = i_cfg.device_address;
                    n_bit_index = 3'd0;
                    enter       = 1'b1;
                    target      = swlct_pkg::PH_ADDR_LOW;
                end
            end
            default: begin
            end
        endcase
    end

    // Segment entry: the new segment's level shows at once and its duration loads.
    always_comb begin
        n_phase     = r_phase;
        n_line      = r_line;
        n_remaining = cnt_next;
        if (enter) begin
            n_phase = target;
            case (target)
                swlct_pkg::PH_EN_SHUT: begin
                    n_line      = 1'b0;
                    n_remaining = swlct_pkg::dur(i_cfg.shutdown_time);
                end
                swlct_pkg::PH_EN_DELAY: begin
                    n_line      = 1'b1;
                    n_remaining = swlct_pkg::dur(i_cfg.detect_delay);
                end
                swlct_pkg::PH_EN_DETECT: begin
                    n_line      = 1'b0;
                    n_remaining = swlct_pkg::dur(i_cfg.detect_window);
                end
                swlct_pkg::PH_EN_SETTLE: begin
                    n_line      = 1'b1;
                    n_remaining = swlct_pkg::dur(i_cfg.settle_time);
                end
                swlct_pkg::PH_ADDR_LOW,
                swlct_pkg::PH_DATA_LOW: begin
                    n_line      = 1'b0;
                    n_remaining = swlct_pkg::dur(16'(n_shift[7] ? i_cfg.short_time
                                                                : i_cfg.long_time));
                end
                swlct_pkg::PH_ADDR_HIGH,
                swlct_pkg::PH_DATA_HIGH: begin
                    n_line      = 1'b1;
                    n_remaining = swlct_pkg::dur(16'(n_shift[7] ? i_cfg.long_time
                                                                : i_cfg.short_time));
                end
                swlct_pkg::PH_GAP_HIGH_A,
                swlct_pkg::PH_GAP_HIGH_B: begin
                    n_line      = 1'b1;
                    n_remaining = swlct_pkg::dur(16'(i_cfg.short_time));
                end
                swlct_pkg::PH_GAP_LOW,
                swlct_pkg::PH_END_LOW: begin
                    n_line      = 1'b0;
                    n_remaining = swlct_pkg::dur(16'(i_cfg.short_time));
                end
                swlct_pkg::PH_END_HIGH: begin
                    n_line      = 1'b1;
                    n_remaining = swlct_pkg::dur(i_cfg.latch_time);
                end
                default: begin
                    n_phase     = swlct_pkg::PH_IDLE;
                    n_line      = 1'b1;
                    n_remaining = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= swlct_pkg::PH_IDLE;
            r_remaining <= '0;
            r_bit_index <= 3'd0;
            r_shift     <= 8'd0;
            r_line      <= 1'b1;
            r_pending   <= 5'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_bit_index <= n_bit_index;
            r_shift     <= n_shift;
            r_line      <= n_line;
            r_pending   <= n_pending;
        end
    end

    assign o_res.line     = n_line;
    assign o_res.busy_res = (n_phase != swlct_pkg::PH_IDLE);
    assign o_res.rejected = rej;

endmodule

[design/single_wire_level_command_transmitter.sv]
// Single-wire level command transmitter, top level.
// A request passes through stage one and then the result register, either of
// which holds while a result waits untaken. Throughput: one request per cycle
// while results are taken; the sequencer state updates in one pass.
// Reset (synchronous, active low) empties both stages, idles the line high
// and loads every configuration register with its default value.
// Depends on swlct_pkg, the channel interfaces, swlct_seq and the defines header.
`include "single_wire_level_command_transmitter_defines.svh"

module single_wire_level_command_transmitter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    swlct_cmd_if.sink    i_cmd,
    swlct_res_if.source  o_res,
    swlct_cfg_if.sink    i_cfg
);

    // Configuration registers. Writes are always taken; the user only writes
    // them while no request is in flight, so the sequencer sees stable values.
    swlct_pkg::t_cfg    r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= swlct_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                swlct_pkg::REG_SHORT_TIME:     r_cfg.short_time     <= i_cfg.data[7:0];
                swlct_pkg::REG_LONG_TIME:      r_cfg.long_time      <= i_cfg.data[7:0];
                swlct_pkg::REG_SHUTDOWN_TIME:  r_cfg.shutdown_time  <= i_cfg.data;
                swlct_pkg::REG_DETECT_DELAY:   r_cfg.detect_delay   <= i_cfg.data;
                swlct_pkg::REG_DETECT_WINDOW:  r_cfg.detect_window  <= i_cfg.data;
                swlct_pkg::REG_SETTLE_TIME:    r_cfg.settle_time    <= i_cfg.data;
                swlct_pkg::REG_LATCH_TIME:     r_cfg.latch_time     <= i_cfg.data;
                swlct_pkg::REG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // Stage one holds the accepted request. It moves on whenever the result
    // register is empty or its result is being taken in the same cycle, so
    // requests flow back to back while the receiver keeps up. A result that
    // waits with stage one full holds the request input off.
    logic                              r_s1_valid;
    logic [swlct_pkg::KIND_W-1:0]      r_s1_kind;
    logic [swlct_pkg::LEVEL_W-1:0]     r_s1_level;
    logic                              r_out_valid;
    swlct_pkg::t_result                r_out;
    swlct_pkg::t_result                seq_res;
    logic                              s1_adv;
    logic                              in_ready;
    logic                              in_take;

    assign s1_adv   = r_s1_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_s1_valid || s1_adv;
    assign in_take  = i_cmd.valid && in_ready;
    assign i_cmd.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_kind  <= i_cmd.kind;
            r_s1_level <= i_cmd.level;
        end
    end

    // The sequencer applies the request held in stage one when it advances
    // and returns the line, busy and reject flags that follow from it.
    swlct_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_adv),
        .i_kind  (r_s1_kind),
        .i_level (r_s1_level),
        .i_cfg   (r_cfg),
        .o_res   (seq_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.line     = r_out.line;
    assign o_res.busy_res = r_out.busy_res;
    assign o_res.rejected = r_out.rejected;

    // A rejected request leaves the sequence running.
    `SWLCT_ASSERT_IMP(a_reject_busy, i_clk, i_rst_n, r_out_valid && r_out.rejected, r_out.busy_res)
    // With no sequence running the line rests high.
    `SWLCT_ASSERT_IMP(a_idle_high, i_clk, i_rst_n, r_out_valid && !r_out.busy_res, r_out.line)
    // A request leaving stage one always lands in the result register.
    `SWLCT_ASSERT_NXT(a_s1_to_out, i_clk, i_rst_n, s1_adv, r_out_valid)
    // An empty result register never holds back stage one.
    `SWLCT_ASSERT_IMP(a_empty_ready, i_clk, i_rst_n, !r_out_valid, in_ready)

endmodule
